// ----- sv/edf_pkg.sv -----
package edf_pkg;

    localparam int MAX_TASKS  = 4;
    localparam int TASK_IDX_W = 2;
    localparam int WORK_W     = 16;
    localparam int TTD_W      = 17;
    localparam int TIME_W     = 32;
    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 16;
    localparam int S_TDATA_W  = 8;
    localparam int M_TDATA_W  = 40;

    // register map: bank in cfg_addr[3:2], task slot in cfg_addr[1:0]
    localparam logic [1:0] BANK_EXEC   = 2'd0;
    localparam logic [1:0] BANK_PERIOD = 2'd1;

    // most negative relative deadline; late tasks saturate here
    localparam logic signed [TTD_W-1:0] TTD_MIN = {1'b1, {(TTD_W-1){1'b0}}};

    typedef struct packed {
        logic step;
        logic exec_we;
        logic period_we;
        logic grant;
    } task_ctrl_t;

    typedef struct packed {
        logic                    ready;
        logic signed [TTD_W-1:0] ttd;
    } task_stat_t;

    // first field in the highest bits, last field in the lowest bits
    typedef struct packed {
        logic [TASK_IDX_W-1:0] run_task;
        logic                  idle;
        logic [TIME_W-1:0]     slot_time;
    } result_t;

endpackage

// ----- sv/edf_task.sv -----
module edf_task
    import edf_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  task_ctrl_t            ctrl,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output task_stat_t            stat
);

    logic [WORK_W-1:0]       exec_reg;
    logic [WORK_W-1:0]       period_reg;
    logic [WORK_W-1:0]       cd_reg;
    logic [WORK_W-1:0]       cd_next;
    logic [WORK_W-1:0]       work_reg;
    logic [WORK_W-1:0]       work_rel;
    logic [WORK_W-1:0]       work_next;
    logic signed [TTD_W-1:0] ttd_reg;
    logic signed [TTD_W-1:0] ttd_rel;
    logic signed [TTD_W-1:0] ttd_next;

    // release phase, then the grant and the deadline advance
    always_comb begin
        cd_next  = cd_reg;
        work_rel = work_reg;
        ttd_rel  = ttd_reg;
        if (period_reg == '0) begin
            cd_next = '0;
        end else if (cd_reg == '0) begin
            cd_next = period_reg - WORK_W'(1);
            if (work_reg == '0) begin
                work_rel = exec_reg;
                ttd_rel  = $signed({1'b0, period_reg});
            end
        end else begin
            cd_next = cd_reg - WORK_W'(1);
        end
        work_next = work_rel - WORK_W'(ctrl.grant);
        ttd_next  = (ttd_rel != TTD_MIN) ? ttd_rel - TTD_W'(1) : ttd_rel;
    end

    assign stat.ready = (period_reg != '0) && (work_rel != '0);
    assign stat.ttd   = ttd_rel;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            exec_reg   <= '0;
            period_reg <= '0;
            cd_reg     <= '0;
            work_reg   <= '0;
            ttd_reg    <= '0;
        end else begin
            if (ctrl.exec_we) begin
                exec_reg <= cfg_wdata;
            end
            if (ctrl.period_we) begin
                period_reg <= cfg_wdata;
            end
            if (ctrl.step) begin
                cd_reg   <= cd_next;
                work_reg <= work_next;
                ttd_reg  <= ttd_next;
            end
        end
    end

endmodule

// ----- sv/edf_pick.sv -----
module edf_pick
    import edf_pkg::*;
#(
    parameter int NUM_TASKS = MAX_TASKS
) (
    input  task_stat_t            stat [NUM_TASKS],
    output logic [NUM_TASKS-1:0]  grant,
    output logic                  idle,
    output logic [TASK_IDX_W-1:0] run_task
);

    logic                    found;
    logic signed [TTD_W-1:0] best;
    logic [TASK_IDX_W-1:0]   idx;

    // strict less-than keeps the lowest index on ties
    always_comb begin
        found = 1'b0;
        best  = '0;
        idx   = '0;
        for (int i = 0; i < NUM_TASKS; i++) begin
            if (stat[i].ready && (!found || $signed(stat[i].ttd) < best)) begin
                found = 1'b1;
                best  = $signed(stat[i].ttd);
                idx   = TASK_IDX_W'(i);
            end
        end
        for (int i = 0; i < NUM_TASKS; i++) begin
            grant[i] = found && (idx == TASK_IDX_W'(i));
        end
    end

    assign idle     = !found;
    assign run_task = idx;

endmodule

// ----- sv/edf_skid.sv -----
module edf_skid
    import edf_pkg::*;
#(
    parameter int W = M_TDATA_W
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         in_valid,
    output logic         in_ready,
    input  logic [W-1:0] in_data,
    output logic         out_valid,
    input  logic         out_ready,
    output logic [W-1:0] out_data
);

    logic         out_valid_reg;
    logic         skid_valid_reg;
    logic [W-1:0] out_data_reg;
    logic [W-1:0] skid_data_reg;
    logic         out_load;

    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_load  = out_ready || !out_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg  <= skid_valid_reg || in_valid;
            skid_valid_reg <= 1'b0;
        end else if (in_valid && in_ready) begin
            // output stalled: park the transfer
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : in_data;
        end
        if (!out_load && in_valid && in_ready) begin
            skid_data_reg <= in_data;
        end
    end

`ifndef SYNTH
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held with empty output stage");
    a_skid_fill_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (!skid_valid_reg ##1 skid_valid_reg) |-> $past(out_valid_reg && !out_ready))
        else $error("skid filled without an output stall");
`endif

endmodule

// ----- sv/edf_tick_scheduler.sv -----
// Earliest-deadline-first tick scheduler for up to NUM_TASKS periodic tasks.
// s_axis: one transfer per tick; tdata[0] = time_step. A transfer with
//   time_step low is consumed and changes nothing.
// m_axis: one decision per tick with time_step high; tdata fields from bit 0:
//   slot_time[31:0], idle[32], run_task[34:33], zeros above.
// cfg: cfg_we writes cfg_wdata to register cfg_addr at the clock edge.
//   0..3 exec_time of tasks 0..3, 4..7 period of tasks 0..3 (0 disables),
//   other addresses ignored. Write only while the block is idle.
// The decision is registered as the tick is taken (skid entry if m_axis stalls).
// Throughput: one tick per clock while s_axis_tready is high; releases, the deadline
//   compare across tasks and the state update all finish in the cycle the tick is taken.
// Reset (aresetn low, synchronous): time, countdowns, work, deadlines, config and skid valid
//   flags clear, skid data does not; every task is released on its first enabled tick.
// Stall: an output register plus one skid entry absorb a stalled m_axis;
//   s_axis_tready drops only once the skid entry holds a decision.
module edf_tick_scheduler
    import edf_pkg::*;
#(
    parameter int NUM_TASKS = MAX_TASKS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [S_TDATA_W-1:0]  s_axis_tdata,   // [0] time_step
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [M_TDATA_W-1:0]  m_axis_tdata,   // [31:0] slot_time, [32] idle, [34:33] run_task
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    logic [TIME_W-1:0]     time_reg;
    logic                  step;
    task_stat_t            stat [NUM_TASKS];
    logic [NUM_TASKS-1:0]  grant;
    logic                  idle;
    logic [TASK_IDX_W-1:0] run_task;
    result_t               result;
    logic [1:0]            cfg_bank;
    logic [TASK_IDX_W-1:0] cfg_slot;

    assign step     = s_axis_tvalid && s_axis_tready && s_axis_tdata[0];
    assign cfg_bank = cfg_addr[3:2];
    assign cfg_slot = cfg_addr[1:0];

    for (genvar i = 0; i < NUM_TASKS; i++) begin : g_task
        task_ctrl_t ctrl;

        assign ctrl.step      = step;
        assign ctrl.exec_we   = cfg_we && (cfg_bank == BANK_EXEC)
                                && (cfg_slot == TASK_IDX_W'(i));
        assign ctrl.period_we = cfg_we && (cfg_bank == BANK_PERIOD)
                                && (cfg_slot == TASK_IDX_W'(i));
        assign ctrl.grant     = grant[i];

        edf_task u_task (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctrl      (ctrl),
            .cfg_wdata (cfg_wdata),
            .stat      (stat[i])
        );
    end

    edf_pick #(
        .NUM_TASKS (NUM_TASKS)
    ) u_pick (
        .stat     (stat),
        .grant    (grant),
        .idle     (idle),
        .run_task (run_task)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            time_reg <= '0;
        end else if (step) begin
            time_reg <= time_reg + TIME_W'(1);
        end
    end

    assign result.slot_time = time_reg;
    assign result.idle      = idle;
    assign result.run_task  = run_task;

    edf_skid #(
        .W (M_TDATA_W)
    ) u_skid (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_axis_tvalid && s_axis_tdata[0]),
        .in_ready  (s_axis_tready),
        .in_data   (M_TDATA_W'(result)),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata)
    );

`ifndef SYNTH
    a_time_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        step |=> time_reg == $past(time_reg) + TIME_W'(1))
        else $error("time did not advance on a tick");
    a_time_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !step |=> $stable(time_reg))
        else $error("time moved without a tick");
    a_idle_no_task: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tdata[32]) |-> (m_axis_tdata[34:33] == '0))
        else $error("idle decision names a task");
`endif

endmodule
